/* sv/jac_pkg.sv */
// jac_pkg: shared types and constants of the joystick axis conditioner
// depends on nothing; used by the arithmetic units and the top level
`default_nettype none
package jac_pkg;

   // command codes of a request
   typedef enum logic [2:0] {
      CMD_X     = 3'd0,
      CMD_Y     = 3'd1,
      CMD_FACE  = 3'd2,
      CMD_START = 3'd3,
      CMD_POLL  = 3'd4
   } cmd_type;

   // register indexes of the configuration port
   localparam logic [2:0] REG_X_NEG  = 3'd0;
   localparam logic [2:0] REG_X_POS  = 3'd1;
   localparam logic [2:0] REG_X_FUZZ = 3'd2;
   localparam logic [2:0] REG_X_FLAT = 3'd3;
   localparam logic [2:0] REG_Y_NEG  = 3'd4;
   localparam logic [2:0] REG_Y_POS  = 3'd5;
   localparam logic [2:0] REG_Y_FUZZ = 3'd6;
   localparam logic [2:0] REG_Y_FLAT = 3'd7;

   localparam int QBITS    = 16;
   localparam int CSR_IDX  = 3;
   localparam int CSR_DATA = 16;

   // start and operands of the shared divider (num < den)
   typedef struct packed {
      logic        start;
      logic [15:0] num;
      logic [15:0] den;
   } div_req_type;

   // start and radicand of the square root unit
   typedef struct packed {
      logic        start;
      logic [31:0] radicand;
   } sqrt_req_type;

endpackage
`default_nettype wire

/* sv/jac_req_if.sv */
// jac_req_if: request channel carrying one gamepad event
// depends on nothing
`default_nettype none
interface jac_req_if #(parameter int SAMPLE_BITS = 16);
   logic                          valid;
   logic                          ready;
   logic [2:0]                    cmd;
   logic signed [SAMPLE_BITS-1:0] sample;
   modport source (output valid, cmd, sample, input ready);
   modport sink (input valid, cmd, sample, output ready);
endinterface
`default_nettype wire

/* sv/jac_rsp_if.sv */
// jac_rsp_if: response channel carrying the polled stick and key flags
// depends on nothing
`default_nettype none
interface jac_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] stick_x;
   logic signed [15:0] stick_y;
   logic               button_down;
   logic               button_pressed;
   logic               start_pressed;
   modport source (output valid, stick_x, stick_y, button_down, button_pressed,
                   start_pressed, input ready);
   modport sink (input valid, stick_x, stick_y, button_down, button_pressed,
                 start_pressed, output ready);
endinterface
`default_nettype wire

/* sv/jac_csr_if.sv */
// jac_csr_if: configuration write channel, register index and data
// depends on nothing
`default_nettype none
interface jac_csr_if;
   logic        valid;
   logic        ready;
   logic [2:0]  index;
   logic [15:0] data;
   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* sv/joystick_axis_conditioner_top.sv */
// joystick_axis_conditioner_top: event sequencer, state and configuration registers
// depends on jac_pkg, jac_req_if, jac_rsp_if, jac_csr_if, jac_div, jac_sqrt
//
// Conditions gamepad events one request at a time. An axis sample passes the dead zone
// and fuzz filter and is scaled to Q1.15 by the shared 15-step divider. Key events only
// update the key state. A poll squares both axes on one multiplier, and when the stick
// lies outside the unit circle takes a 16-step square root and two divisions. The response
// is held in an output register, so the next request is taken while it waits.
// Configuration writes are taken in any cycle and must only be made while the block is idle.
`default_nettype none
module joystick_axis_conditioner_top
   import jac_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
)(
   input  wire logic clock,
   input  wire logic reset,
   jac_req_if.sink   req_chan,
   jac_rsp_if.source rsp_chan,
   jac_csr_if.sink   csr_chan
);

   localparam int SB = SAMPLE_BITS;
   localparam int CW = (SB > 17) ? SB + 2 : 19;

   typedef enum logic [3:0] {
      ST_IDLE, ST_COND, ST_SCALE, ST_NORM_X, ST_NORM_Y, ST_DIV_GO, ST_DIV_WAIT,
      ST_SQ_X, ST_SQ_Y, ST_SQ_SUM, ST_SQ_CHECK, ST_SQRT_GO, ST_SQRT_WAIT, ST_EMIT
   } state_type;

   state_type state_ff;

   // configuration registers
   logic signed [15:0] x_neg_ff, y_neg_ff;
   logic [14:0]        x_pos_ff, y_pos_ff, x_fuzz_ff, y_fuzz_ff;
   logic [12:0]        x_flat_ff, y_flat_ff;

   // block state
   logic signed [SB-1:0] raw_x_ff, raw_y_ff;
   logic signed [15:0]   scaled_x_ff, scaled_y_ff;
   logic face_down_ff, face_flag_ff, start_down_ff, start_flag_ff;

   // latched request
   logic [2:0]           cmd_ff;
   logic signed [SB-1:0] sample_ff;

   // division context
   logic        tgt_y_ff, norm_ff, vneg_ff, sgn_ff, big_ff;
   logic [15:0] num_ff, den_ff;

   // poll arithmetic
   logic [30:0] prod_ff;
   logic [31:0] acc_ff;
   logic [15:0] root_ff;

   // response register
   logic               rsp_valid_ff;
   logic signed [15:0] rsp_x_ff, rsp_y_ff;
   logic               rsp_down_ff, rsp_bp_ff, rsp_sp_ff;

   div_req_type  div_req;
   sqrt_req_type sqrt_req;
   logic         div_done, sqrt_done;
   logic [14:0]  div_quot;
   logic [15:0]  sqrt_root;

   jac_div u_div (
      .clock (clock), .reset (reset), .req (div_req), .done (div_done), .quot (div_quot)
   );

   jac_sqrt u_sqrt (
      .clock (clock), .reset (reset), .req (sqrt_req), .done (sqrt_done), .root (sqrt_root)
   );

   // dead zone and fuzz filter on the latched sample
   logic signed [SB-1:0] cur_raw, raw_in;
   logic [14:0]          fuzz_sel;
   logic [12:0]          flat_sel;
   logic [SB-1:0]        abs_sample;
   logic signed [SB:0]   diff;
   logic [SB:0]          abs_diff;
   logic [CW-1:0]        flat4;

   always_comb begin
      cur_raw    = (cmd_ff == CMD_Y) ? raw_y_ff : raw_x_ff;
      fuzz_sel   = (cmd_ff == CMD_Y) ? y_fuzz_ff : x_fuzz_ff;
      flat_sel   = (cmd_ff == CMD_Y) ? y_flat_ff : x_flat_ff;
      abs_sample = sample_ff[SB-1] ? SB'(-sample_ff) : SB'(sample_ff);
      diff       = (SB+1)'(sample_ff) - (SB+1)'(cur_raw);
      abs_diff   = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
      flat4      = CW'({flat_sel, 2'b00});
      if (CW'(abs_sample) < flat4) begin
         raw_in = '0;
      end else if (CW'(abs_diff) < CW'(fuzz_sel)) begin
         raw_in = cur_raw;
      end else begin
         raw_in = sample_ff;
      end
   end

   // divisor selection for scaling the stored raw value
   logic signed [SB-1:0] scale_v;
   logic [SB-1:0]        abs_v;
   logic signed [16:0]   div_sel;
   logic [16:0]          abs_d;

   always_comb begin
      scale_v = tgt_y_ff ? raw_y_ff : raw_x_ff;
      abs_v   = scale_v[SB-1] ? SB'(-scale_v) : SB'(scale_v);
      if (scale_v[SB-1]) begin
         div_sel = 17'(tgt_y_ff ? y_neg_ff : x_neg_ff);
      end else begin
         div_sel = signed'({2'b00, (tgt_y_ff ? y_pos_ff : x_pos_ff)});
      end
      abs_d = div_sel[16] ? 17'(-div_sel) : 17'(div_sel);
   end

   // signed result with saturation from the quotient magnitude
   logic [16:0]        mag;
   logic signed [17:0] t_val, u_val, neg_val;
   logic signed [15:0] sat_u, fin_val;

   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      if (v > 18'sd32767) begin
         return 16'sh7fff;
      end else if (v < -18'sd32768) begin
         return 16'sh8000;
      end
      return v[15:0];
   endfunction

   always_comb begin
      mag     = big_ff ? 17'h10000 : {2'b00, div_quot};
      t_val   = sgn_ff ? -signed'({1'b0, mag}) : signed'({1'b0, mag});
      u_val   = vneg_ff ? -t_val : t_val;
      sat_u   = sat16(u_val);
      neg_val = -18'(sat_u);
      fin_val = (tgt_y_ff && !norm_ff) ? sat16(neg_val) : sat_u;
   end

   // shared multiplier for the squares
   logic signed [15:0] mul_op;
   logic signed [31:0] mul_res;
   assign mul_op  = (state_ff == ST_SQ_X) ? scaled_x_ff : scaled_y_ff;
   assign mul_res = mul_op * mul_op;

   // magnitude of an axis for normalisation
   logic signed [15:0] norm_v;
   logic [15:0]        norm_abs;
   assign norm_v   = (state_ff == ST_NORM_Y) ? scaled_y_ff : scaled_x_ff;
   assign norm_abs = norm_v[15] ? 16'(-norm_v) : 16'(norm_v);

   // unit requests
   always_comb begin
      div_req.start  = (state_ff == ST_DIV_GO) && !big_ff;
      div_req.num    = num_ff;
      div_req.den    = den_ff;
      sqrt_req.start = (state_ff == ST_SQRT_GO);
      sqrt_req.radicand = acc_ff;
   end

   logic rsp_free;
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   // sequencer, state and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         x_neg_ff      <= -16'sd32768;
         y_neg_ff      <= -16'sd32768;
         x_pos_ff      <= 15'd32767;
         y_pos_ff      <= 15'd32767;
         x_fuzz_ff     <= 15'd16;
         y_fuzz_ff     <= 15'd16;
         x_flat_ff     <= 13'd128;
         y_flat_ff     <= 13'd128;
         raw_x_ff      <= '0;
         raw_y_ff      <= '0;
         scaled_x_ff   <= '0;
         scaled_y_ff   <= '0;
         face_down_ff  <= 1'b0;
         face_flag_ff  <= 1'b0;
         start_down_ff <= 1'b0;
         start_flag_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         // configuration writes
         if (csr_chan.valid) begin
            unique case (csr_chan.index)
               REG_X_NEG:  x_neg_ff  <= signed'(csr_chan.data);
               REG_X_POS:  x_pos_ff  <= csr_chan.data[14:0];
               REG_X_FUZZ: x_fuzz_ff <= csr_chan.data[14:0];
               REG_X_FLAT: x_flat_ff <= csr_chan.data[12:0];
               REG_Y_NEG:  y_neg_ff  <= signed'(csr_chan.data);
               REG_Y_POS:  y_pos_ff  <= csr_chan.data[14:0];
               REG_Y_FUZZ: y_fuzz_ff <= csr_chan.data[14:0];
               REG_Y_FLAT: y_flat_ff <= csr_chan.data[12:0];
            endcase
         end

         // response taken and no new one loaded this cycle
         if (rsp_valid_ff && rsp_chan.ready && (state_ff != ST_EMIT)) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (req_chan.valid) begin
                  cmd_ff    <= req_chan.cmd;
                  sample_ff <= req_chan.sample;
                  state_ff  <= ST_COND;
               end
            end
            ST_COND: begin
               unique case (cmd_ff)
                  CMD_X: begin
                     raw_x_ff <= raw_in;
                     tgt_y_ff <= 1'b0;
                     state_ff <= ST_SCALE;
                  end
                  CMD_Y: begin
                     raw_y_ff <= raw_in;
                     tgt_y_ff <= 1'b1;
                     state_ff <= ST_SCALE;
                  end
                  CMD_FACE: begin
                     face_flag_ff <= !face_down_ff;
                     face_down_ff <= sample_ff != '0;
                     state_ff     <= ST_IDLE;
                  end
                  CMD_START: begin
                     start_flag_ff <= !start_down_ff;
                     start_down_ff <= sample_ff != '0;
                     state_ff      <= ST_IDLE;
                  end
                  CMD_POLL: state_ff <= ST_SQ_X;
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_SCALE: begin
               norm_ff <= 1'b0;
               vneg_ff <= scale_v[SB-1];
               sgn_ff  <= scale_v[SB-1] ^ div_sel[16];
               big_ff  <= CW'(abs_v) >= CW'(abs_d);
               num_ff  <= 16'(abs_v);
               den_ff  <= abs_d[15:0];
               if (abs_d == '0) begin
                  if (tgt_y_ff) begin
                     scaled_y_ff <= '0;
                  end else begin
                     scaled_x_ff <= '0;
                  end
                  state_ff <= ST_IDLE;
               end else begin
                  state_ff <= ST_DIV_GO;
               end
            end
            ST_NORM_X, ST_NORM_Y: begin
               norm_ff  <= 1'b1;
               tgt_y_ff <= (state_ff == ST_NORM_Y);
               vneg_ff  <= norm_v[15];
               sgn_ff   <= 1'b0;
               big_ff   <= norm_abs >= root_ff;
               num_ff   <= norm_abs;
               den_ff   <= root_ff;
               state_ff <= ST_DIV_GO;
            end
            ST_DIV_GO, ST_DIV_WAIT: begin
               if ((state_ff == ST_DIV_GO && big_ff) || (state_ff == ST_DIV_WAIT && div_done))
               begin
                  if (tgt_y_ff) begin
                     scaled_y_ff <= fin_val;
                  end else begin
                     scaled_x_ff <= fin_val;
                  end
                  if (!norm_ff) begin
                     state_ff <= ST_IDLE;
                  end else if (!tgt_y_ff) begin
                     state_ff <= ST_NORM_Y;
                  end else begin
                     state_ff <= ST_EMIT;
                  end
               end else begin
                  state_ff <= ST_DIV_WAIT;
               end
            end
            ST_SQ_X: begin
               prod_ff  <= mul_res[30:0];
               state_ff <= ST_SQ_Y;
            end
            ST_SQ_Y: begin
               acc_ff   <= {1'b0, prod_ff};
               prod_ff  <= mul_res[30:0];
               state_ff <= ST_SQ_SUM;
            end
            ST_SQ_SUM: begin
               acc_ff   <= acc_ff + {1'b0, prod_ff};
               state_ff <= ST_SQ_CHECK;
            end
            ST_SQ_CHECK: begin
               state_ff <= (acc_ff > 32'h4000_0000) ? ST_SQRT_GO : ST_EMIT;
            end
            ST_SQRT_GO: state_ff <= ST_SQRT_WAIT;
            ST_SQRT_WAIT: begin
               if (sqrt_done) begin
                  root_ff  <= sqrt_root;
                  state_ff <= ST_NORM_X;
               end
            end
            ST_EMIT: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_x_ff      <= scaled_x_ff;
                  rsp_y_ff      <= scaled_y_ff;
                  rsp_down_ff   <= face_down_ff;
                  rsp_bp_ff     <= face_flag_ff;
                  rsp_sp_ff     <= start_flag_ff;
                  face_flag_ff  <= 1'b0;
                  start_flag_ff <= 1'b0;
                  state_ff      <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_chan.ready          = (state_ff == ST_IDLE);
   assign csr_chan.ready          = 1'b1;
   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.stick_x        = rsp_x_ff;
   assign rsp_chan.stick_y        = rsp_y_ff;
   assign rsp_chan.button_down    = rsp_down_ff;
   assign rsp_chan.button_pressed = rsp_bp_ff;
   assign rsp_chan.start_pressed  = rsp_sp_ff;

endmodule
`default_nettype wire

/* sv/jac_div.sv */
// jac_div: restoring divider, one quotient bit a cycle, 15-bit fraction of num/den
// depends on jac_pkg; requires num < den
`default_nettype none
module jac_div
   import jac_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type req,
   output logic             done,
   output logic [14:0]      quot
);

   logic [15:0] rem_ff;
   logic [15:0] den_ff;
   logic [14:0] quot_ff;
   logic [3:0]  count_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [16:0] rem_sh;
   logic        fits;

   // trial subtract of the doubled remainder
   assign rem_sh = {rem_ff, 1'b0};
   assign fits   = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= 4'd14;
            rem_ff   <= req.num;
            den_ff   <= req.den;
         end else if (busy_ff) begin
            quot_ff <= {quot_ff[13:0], fits};
            rem_ff  <= fits ? 16'(rem_sh - {1'b0, den_ff}) : rem_sh[15:0];
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            count_ff <= count_ff - 4'd1;
         end
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;

endmodule
`default_nettype wire

/* sv/jac_sqrt.sv */
// jac_sqrt: digit-by-digit integer square root, one result bit a cycle
// depends on jac_pkg
`default_nettype none
module jac_sqrt
   import jac_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire sqrt_req_type req,
   output logic              done,
   output logic [15:0]       root
);

   logic [31:0] rad_ff;
   logic [17:0] rem_ff;
   logic [15:0] root_ff;
   logic [3:0]  count_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [19:0] rem_sh;
   logic [19:0] trial;
   logic        fits;

   // bring down two radicand bits and try root*4+1
   assign rem_sh = {rem_ff, rad_ff[31:30]};
   assign trial  = {2'b00, root_ff, 2'b01};
   assign fits   = rem_sh >= trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff  <= 1'b1;
            count_ff <= 4'd15;
            rad_ff   <= req.radicand;
            rem_ff   <= '0;
            root_ff  <= '0;
         end else if (busy_ff) begin
            rad_ff  <= {rad_ff[29:0], 2'b00};
            rem_ff  <= fits ? 18'(rem_sh - trial) : rem_sh[17:0];
            root_ff <= {root_ff[14:0], fits};
            if (count_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            count_ff <= count_ff - 4'd1;
         end
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule
`default_nettype wire

/* tb/tb.sv */
// tb: self-checking bench for the joystick axis conditioner
// depends on jac_pkg, jac_req_if, jac_rsp_if, jac_csr_if and joystick_axis_conditioner_top
`default_nettype none
module tb;
   import jac_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam longint Q_ONE      = 32768;
   localparam int     CYCLE_CAP  = 3000000;
   localparam int     SETTLE     = 120;
   localparam int     RAND_ITEMS = 175;

   typedef struct {
      logic [2:0]         cmd;
      logic signed [15:0] sample;
   } event_type;

   typedef struct {
      logic signed [15:0] stick_x;
      logic signed [15:0] stick_y;
      logic               button_down;
      logic               button_pressed;
      logic               start_pressed;
   } poll_type;

   logic clock;
   logic reset;

   jac_req_if #(.SAMPLE_BITS(16)) req_bus ();
   jac_rsp_if rsp_bus ();
   jac_csr_if csr_bus ();

   joystick_axis_conditioner_top #(.SAMPLE_BITS(16)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // shadow of the conditioner state and registers, axis 0 is x, axis 1 is y
   longint axis_neg [2];
   longint axis_pos [2];
   longint axis_fuzz [2];
   longint axis_flat [2];
   longint axis_raw [2];
   longint axis_scaled [2];
   bit     face_down, face_flag, start_down, start_flag;

   event_type pending_events [$];
   poll_type  polls_due [$];
   bit        event_busy;
   bit        event_taken;
   int        event_gap;
   bit        gap_free;
   int        rsp_stall;
   int        rsp_hold;
   bit        rsp_taken;
   int        mismatches;
   int        polls_checked;
   int        events_sent;
   int        phases_run;
   int        cycles;

   // clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic longint sat16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic longint abs64(longint v);
      return (v < 0) ? -v : v;
   endfunction

   // dead zone first, then the fuzz filter against the held raw value
   function automatic longint filter_axis(longint held, longint fuzz, longint flat,
                                          longint smp);
      if (abs64(smp) < flat * 4) return 0;
      return (abs64(smp - held) < fuzz) ? held : smp;
   endfunction

   function automatic longint scale_axis(longint v, longint neg, longint pos);
      if (v < 0) begin
         if (neg == 0) return 0;
         return sat16(-((v * Q_ONE) / neg));
      end
      if (pos == 0) return 0;
      return sat16((v * Q_ONE) / pos);
   endfunction

   function automatic longint floor_sqrt(longint s);
      longint r;
      longint b;
      r = 0;
      b = longint'(1) << 32;
      while (b > s) b = b >> 2;
      while (b != 0) begin
         if (s >= r + b) begin
            s = s - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // update the shadow for one accepted request, queue a poll result
   task automatic predict_event(event_type ev);
      longint   smp;
      longint   sq;
      longint   root;
      poll_type p;
      smp = ev.sample;
      case (ev.cmd)
         CMD_X: begin
            axis_raw[0] = filter_axis(axis_raw[0], axis_fuzz[0], axis_flat[0], smp);
            axis_scaled[0] = scale_axis(axis_raw[0], axis_neg[0], axis_pos[0]);
         end
         CMD_Y: begin
            axis_raw[1] = filter_axis(axis_raw[1], axis_fuzz[1], axis_flat[1], smp);
            axis_scaled[1] = sat16(-scale_axis(axis_raw[1], axis_neg[1], axis_pos[1]));
         end
         CMD_FACE: begin
            face_flag = !face_down;
            face_down = (smp != 0);
         end
         CMD_START: begin
            start_flag = !start_down;
            start_down = (smp != 0);
         end
         CMD_POLL: begin
            sq = axis_scaled[0] * axis_scaled[0] + axis_scaled[1] * axis_scaled[1];
            if (sq > (longint'(1) << 30)) begin
               root = floor_sqrt(sq);
               axis_scaled[0] = sat16((axis_scaled[0] * Q_ONE) / root);
               axis_scaled[1] = sat16((axis_scaled[1] * Q_ONE) / root);
            end
            p.stick_x        = axis_scaled[0][15:0];
            p.stick_y        = axis_scaled[1][15:0];
            p.button_down    = face_down;
            p.button_pressed = face_flag;
            p.start_pressed  = start_flag;
            polls_due.push_back(p);
            face_flag  = 1'b0;
            start_flag = 1'b0;
         end
         default: ;
      endcase
   endtask

   task automatic apply_reg(logic [2:0] idx, logic [15:0] data);
      int ax;
      ax = idx[2];
      case (idx)
         REG_X_NEG, REG_Y_NEG:   axis_neg[ax]  = longint'(signed'(data));
         REG_X_POS, REG_Y_POS:   axis_pos[ax]  = data[14:0];
         REG_X_FUZZ, REG_Y_FUZZ: axis_fuzz[ax] = data[14:0];
         REG_X_FLAT, REG_Y_FLAT: axis_flat[ax] = data[12:0];
         default: ;
      endcase
   endtask

   // request acceptance and prediction
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready) begin
         event_type ev;
         ev.cmd    = req_bus.cmd;
         ev.sample = req_bus.sample;
         predict_event(ev);
         event_taken = 1'b1;
         event_busy  = 1'b0;
      end
   end

   // request driver, fed from the pending queue
   always @(negedge clock) begin
      logic nv;
      nv = req_bus.valid;
      if (event_taken) begin
         nv = 1'b0;
         event_taken = 1'b0;
      end
      if (!reset && !nv) begin
         if (event_gap > 0) begin
            event_gap--;
         end else if (pending_events.size() != 0) begin
            event_type ev;
            ev = pending_events.pop_front();
            req_bus.cmd    <= ev.cmd;
            req_bus.sample <= ev.sample;
            nv = 1'b1;
            event_busy = 1'b1;
            events_sent++;
            event_gap = gap_free ? 0 : $urandom_range(0, 18);
         end
      end
      req_bus.valid <= nv;
   end

   // response monitor and checker
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         poll_type p;
         rsp_taken = 1'b1;
         if (polls_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected response x=%0d y=%0d", rsp_bus.stick_x, rsp_bus.stick_y);
         end else begin
            p = polls_due.pop_front();
            polls_checked++;
            if (p.stick_x !== rsp_bus.stick_x || p.stick_y !== rsp_bus.stick_y ||
                p.button_down !== rsp_bus.button_down ||
                p.button_pressed !== rsp_bus.button_pressed ||
                p.start_pressed !== rsp_bus.start_pressed) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("poll %0d: expected x=%0d y=%0d d=%b p=%b s=%b, got x=%0d y=%0d d=%b p=%b s=%b",
                           polls_checked, p.stick_x, p.stick_y, p.button_down,
                           p.button_pressed, p.start_pressed, rsp_bus.stick_x,
                           rsp_bus.stick_y, rsp_bus.button_down, rsp_bus.button_pressed,
                           rsp_bus.start_pressed);
            end
         end
      end
   end

   // response ready, random stalls plus the long hold-off
   always @(negedge clock) begin
      logic nr;
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_stall = gap_free ? 0 : $urandom_range(0, 18);
      end
      if (rsp_hold > 0) begin
         rsp_hold--;
         nr = 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         nr = 1'b0;
      end else begin
         nr = !reset;
      end
      rsp_bus.ready <= nr;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [15:0] data);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data  <= data;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      apply_reg(idx, data);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic write_axis(int ax, logic [15:0] neg, logic [15:0] pos,
                             logic [15:0] fuzz, logic [15:0] flat);
      logic [2:0] base;
      base = (ax == 0) ? REG_X_NEG : REG_Y_NEG;
      write_reg(base, neg);
      write_reg(base + 3'd1, pos);
      write_reg(base + 3'd2, fuzz);
      write_reg(base + 3'd3, flat);
   endtask

   task automatic wait_idle();
      while (pending_events.size() != 0 || event_busy || req_bus.valid ||
             polls_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic push_event(logic [2:0] c, longint s);
      event_type ev;
      ev.cmd    = c;
      ev.sample = s[15:0];
      pending_events.push_back(ev);
   endtask

   // axis samples aimed at the dead zone edge, the fuzz window and the extremes
   function automatic longint pick_sample(int ax);
      case ($urandom_range(0, 5))
         0: return longint'(signed'(16'($urandom())));
         1: return ($urandom_range(0, 1) ? 1 : -1) * (axis_flat[ax] * 4) +
                   $signed($urandom_range(0, 6)) - 3;
         2: return axis_raw[ax] + axis_fuzz[ax] + $signed($urandom_range(0, 4)) - 2;
         3: return axis_raw[ax] - axis_fuzz[ax] + $signed($urandom_range(0, 4)) - 2;
         4: return $urandom_range(0, 1) ? 32767 - $urandom_range(0, 3)
                                         : -32768 + $urandom_range(0, 3);
         default: return $signed($urandom_range(0, 2000)) - 1000;
      endcase
   endfunction

   task automatic random_events(int n);
      int k;
      for (k = 0; k < n; k++) begin
         case ($urandom_range(0, 15))
            0, 1, 2, 3:  push_event(CMD_X, pick_sample(0));
            4, 5, 6, 7:  push_event(CMD_Y, pick_sample(1));
            8, 9:        push_event(CMD_FACE, $urandom_range(0, 2) == 0 ?
                                    longint'(signed'(16'($urandom()))) : $urandom_range(0, 1));
            10, 11:      push_event(CMD_START, $urandom_range(0, 2) == 0 ?
                                    longint'(signed'(16'($urandom()))) : $urandom_range(0, 1));
            12, 13, 14:  push_event(CMD_POLL, longint'(signed'(16'($urandom()))));
            default: begin
               // ignored codes, an extra on top of the count
               push_event(3'($urandom_range(5, 7)), longint'(signed'(16'($urandom()))));
               k--;
            end
         endcase
         if ($urandom_range(0, 63) == 0) begin
            push_event(3'($urandom_range(5, 7)), 0);
         end
      end
   endtask

   // main sequence: directed items, then configuration phases with random traffic
   initial begin
      int ph;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = CMD_X;
      req_bus.sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = REG_X_NEG;
      csr_bus.data = '0;
      rsp_bus.ready = 1'b0;
      event_busy = 0; event_taken = 0; event_gap = 0; gap_free = 0;
      rsp_stall = 0; rsp_hold = 0; rsp_taken = 0;
      mismatches = 0; polls_checked = 0; events_sent = 0; phases_run = 0; cycles = 0;
      for (int a = 0; a < 2; a++) begin
         axis_neg[a] = -32768; axis_pos[a] = 32767; axis_fuzz[a] = 16; axis_flat[a] = 128;
         axis_raw[a] = 0; axis_scaled[a] = 0;
      end
      face_down = 0; face_flag = 0; start_down = 0; start_flag = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes, normalisation, keys, dead zone edge, fuzz, ignored codes
      push_event(CMD_POLL, 0);
      push_event(CMD_X, 32767);
      push_event(CMD_Y, -32768);
      push_event(CMD_POLL, 0);
      push_event(CMD_X, -32768);
      push_event(CMD_Y, 32767);
      push_event(CMD_POLL, 0);
      push_event(CMD_FACE, 1);
      push_event(CMD_FACE, 1);
      push_event(CMD_START, -5);
      push_event(CMD_POLL, 0);
      push_event(CMD_FACE, 0);
      push_event(CMD_START, 0);
      push_event(CMD_POLL, 0);
      push_event(CMD_X, 511);
      push_event(CMD_Y, 512);
      push_event(CMD_POLL, 0);
      push_event(CMD_X, 1000);
      push_event(CMD_X, 1015);
      push_event(CMD_POLL, 0);
      push_event(CMD_X, 1016);
      push_event(3'd5, 77);
      push_event(3'd6, -1);
      push_event(3'd7, 0);
      push_event(CMD_POLL, 0);
      wait_idle();

      for (ph = 0; ph < 7; ph++) begin
         case (ph)
            0: begin
               write_axis(0, 16'h8000, 16'h7FFF, 16'd16, 16'd128);
               write_axis(1, 16'h8000, 16'h7FFF, 16'd16, 16'd128);
            end
            1: begin
               // zero divisors, no fuzz, no dead zone
               write_axis(0, 16'h0000, 16'h0000, 16'd0, 16'd0);
               write_axis(1, 16'h0000, 16'h0000, 16'd0, 16'd0);
            end
            2: begin
               // tiny limits saturate; widest fuzz and dead zone
               write_axis(0, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h1FFF);
               write_axis(1, 16'hFFFF, 16'h0001, 16'h7FFF, 16'h1FFF);
            end
            3: begin
               // negative limits of unusual sign, upper data bits set
               write_axis(0, 16'h1234, 16'hC000, 16'hFFFF, 16'hE010);
               write_axis(1, 16'h7FFF, 16'h8100, 16'h8004, 16'hF000);
            end
            4: begin
               write_axis(0, 16'hC000, 16'h2000, 16'd200, 16'd10);
               write_axis(1, 16'hF000, 16'h4000, 16'd3, 16'd1);
            end
            default: begin
               write_axis(0, 16'($urandom_range(0, 32768) * -1), 16'($urandom()),
                          16'($urandom_range(0, 64)), 16'($urandom_range(0, 300)));
               write_axis(1, 16'($urandom_range(0, 32768) * -1), 16'($urandom()),
                          16'($urandom_range(0, 64)), 16'($urandom_range(0, 300)));
            end
         endcase
         gap_free = (ph == 4);
         // long receiver hold-off so the output register fills and input stalls
         if (ph == 2 || ph == 5) rsp_hold = 600;
         random_events(RAND_ITEMS);
         wait_idle();
         phases_run++;
      end

      $display("%0d requests sent over %0d register settings, %0d polls checked",
               events_sent, phases_run + 1, polls_checked);
      $display("covered dead zone, fuzz, saturation, zero divisors and stick normalisation");
      if (mismatches == 0 && polls_due.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
`default_nettype wire

/* joystick_axis_conditioner_top.f */
sv/jac_pkg.sv
sv/jac_req_if.sv
sv/jac_rsp_if.sv
sv/jac_csr_if.sv
sv/jac_div.sv
sv/jac_sqrt.sv
sv/joystick_axis_conditioner_top.sv
tb/tb.sv
